@@ rtl/bdq_pkg.sv @@
// Shared constants, types and helpers for the bounded deque.
package bdq_pkg;

    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int OCC_W  = ADDR_W + 1;
    localparam int SUM_W  = OCC_W + 1;
    localparam int CAP_W  = 11;
    localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam int KIND_W = 3;
    localparam int DATA_W = 32;

    localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(1024);
    localparam logic [DATA_W-1:0] EMPTY_WORD = '1;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_QUERY      = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic exec;  // apply the accepted word to head, count and store
        logic rd;    // read front and rear entries
        logic load;  // load the result register
    } cmd_t;

    // Ring position off entries past base, modulo DEPTH.
    function automatic logic [ADDR_W-1:0] ring_pos(
        input logic [ADDR_W-1:0] base,
        input logic [OCC_W-1:0]  off
    );
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(off);
        if (s >= SUM_W'(DEPTH))
            s = s - SUM_W'(DEPTH);
        return s[ADDR_W-1:0];
    endfunction

endpackage

@@ rtl/bdq_if.sv @@
// Channel interfaces for the bounded deque: request, response, configuration.
interface bdq_req_if;
    logic                                valid;
    logic                                ready;
    logic        [bdq_pkg::KIND_W-1:0]   kind;
    logic signed [bdq_pkg::DATA_W-1:0]   value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface bdq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                ok;
    logic signed [bdq_pkg::DATA_W-1:0]   front_value;
    logic signed [bdq_pkg::DATA_W-1:0]   rear_value;
    logic                                is_empty;
    logic                                is_full;

    modport source (output valid, output ok, output front_value, output rear_value,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input ok, input front_value, input rear_value,
                    input is_empty, input is_full, output ready);
endinterface

interface bdq_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [bdq_pkg::CAP_W-1:0]     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/bdq_ctrl.sv @@
// Sequencing state machine for the bounded deque.
module bdq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output bdq_pkg::cmd_t cmd
);
    import bdq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (!out_valid_reg || rsp_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready = (state_reg == ST_IDLE);
        cmd.exec  = (state_reg == ST_IDLE) && req_valid;
        cmd.rd    = (state_reg == ST_READ);
        // load only into a free result register
        cmd.load  = (state_reg == ST_LOAD) && (!out_valid_reg || rsp_ready);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
    end

    assign rsp_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> cmd.rd)
        else $error("accepted word not followed by a store read");

    a_read_loads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |=> (state_reg == ST_LOAD))
        else $error("store read not followed by result load");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!rsp_valid || rsp_ready))
        else $error("result register overwritten while held");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !req_ready)
        else $error("second word accepted while one is in flight");

endmodule

@@ rtl/bdq_dpath.sv @@
// Ring store, head and occupancy registers and result register of the deque.
module bdq_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bdq_pkg::cmd_t                       cmd,
    input  logic        [bdq_pkg::KIND_W-1:0]   kind,
    input  logic signed [bdq_pkg::DATA_W-1:0]   value,
    input  logic                                cfg_we,
    input  logic        [bdq_pkg::CAP_W-1:0]    cfg_data,
    output logic                                ok,
    output logic signed [bdq_pkg::DATA_W-1:0]   front_value,
    output logic signed [bdq_pkg::DATA_W-1:0]   rear_value,
    output logic                                is_empty,
    output logic                                is_full
);
    import bdq_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    logic [ADDR_W-1:0] head_reg;
    logic [ADDR_W-1:0] head_next;
    logic [OCC_W-1:0]  occ_reg;
    logic [OCC_W-1:0]  occ_next;
    logic [CAP_W-1:0]  cap_reg;
    logic              ok_reg;
    logic              ok_next;

    logic [DATA_W-1:0] front_rd_reg;
    logic [DATA_W-1:0] rear_rd_reg;

    logic [DATA_W-1:0] front_out_reg;
    logic [DATA_W-1:0] rear_out_reg;
    logic              ok_out_reg;
    logic              empty_out_reg;
    logic              full_out_reg;

    logic [CMP_W-1:0]  eff_cap;
    logic              full;
    logic              empty;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] rear_addr;

    // Capacity saturates at the store depth.
    assign eff_cap = (CMP_W'(cap_reg) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_reg);
    assign full    = CMP_W'(occ_reg) >= eff_cap;
    assign empty   = (occ_reg == '0);

    assign rear_addr = ring_pos(head_reg, occ_reg - OCC_W'(1));

    always_comb
    begin
        head_next = head_reg;
        occ_next  = occ_reg;
        ok_next   = 1'b0;
        we        = 1'b0;
        waddr     = ring_pos(head_reg, occ_reg);
        unique case (kind)
            KIND_PUSH_FRONT:
            begin
                if (!full)
                begin
                    head_next = (head_reg == '0) ? ADDR_W'(DEPTH - 1)
                                                 : head_reg - ADDR_W'(1);
                    waddr     = head_next;
                    we        = 1'b1;
                    occ_next  = occ_reg + OCC_W'(1);
                    ok_next   = 1'b1;
                end
            end
            KIND_PUSH_BACK:
            begin
                if (!full)
                begin
                    we       = 1'b1;
                    occ_next = occ_reg + OCC_W'(1);
                    ok_next  = 1'b1;
                end
            end
            KIND_POP_FRONT:
            begin
                if (!empty)
                begin
                    head_next = ring_pos(head_reg, OCC_W'(1));
                    occ_next  = occ_reg - OCC_W'(1);
                    ok_next   = 1'b1;
                end
            end
            KIND_POP_BACK:
            begin
                if (!empty)
                begin
                    occ_next = occ_reg - OCC_W'(1);
                    ok_next  = 1'b1;
                end
            end
            KIND_QUERY:
            begin
                ok_next = 1'b1;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            occ_reg  <= '0;
            cap_reg  <= CAP_RESET;
        end
        else
        begin
            if (cmd.exec)
            begin
                head_reg <= head_next;
                occ_reg  <= occ_next;
            end
            if (cfg_we)
                cap_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && we)
            mem[waddr] <= value;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            front_rd_reg <= mem[head_reg];
            rear_rd_reg  <= mem[rear_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
            ok_reg <= ok_next;
        if (cmd.load)
        begin
            ok_out_reg    <= ok_reg;
            front_out_reg <= empty ? EMPTY_WORD : front_rd_reg;
            rear_out_reg  <= empty ? EMPTY_WORD : rear_rd_reg;
            empty_out_reg <= empty;
            full_out_reg  <= full;
        end
    end

    assign ok          = ok_out_reg;
    assign front_value = front_out_reg;
    assign rear_value  = rear_out_reg;
    assign is_empty    = empty_out_reg;
    assign is_full     = full_out_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(occ_reg) <= CMP_W'(DEPTH))
        else $error("occupancy above store depth");

    a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> (occ_reg == $past(occ_reg) ||
                      occ_reg == $past(occ_reg) + OCC_W'(1) ||
                      occ_reg == $past(occ_reg) - OCC_W'(1)))
        else $error("occupancy moved by more than one entry");

    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(cmd.exec) |-> ($stable(occ_reg) && $stable(head_reg)))
        else $error("head or occupancy changed without an accepted word");

endmodule

@@ rtl/bounded_double_ended_queue_unit.sv @@
// Top level of the bounded deque: controller, datapath and channel wiring.
//
// Usage:
//   req carries one word per operation: kind (push front, push back, pop
//   front, pop back, query) and value (the word to push). rsp returns one word
//   per request: ok, front and rear words after the operation (-1 when the
//   deque is empty), and the empty and full flags. cfg writes the capacity,
//   which saturates at the 1024-entry store depth; write it only while idle.
//   A request is taken when req.valid and req.ready are high at a clock edge.
//   The response is registered: update and store write at the accepting edge,
//   registered store read, then result load.
//   Only one request is in flight: the next is taken once the current one has
//   been through the store's registered read ports and the result load.
//   A held response does not block acceptance of the next request; if rsp.ready
//   stays low, the next result waits in the load step until the register frees.
//   Reset clears head, occupancy and the response valid and sets capacity to
//   1024; store contents are left as they are, since only live entries are read.
module bounded_double_ended_queue_unit (
    input  logic        clk,
    input  logic        rst_n,
    bdq_req_if.sink     req,
    bdq_rsp_if.source   rsp,
    bdq_cfg_if.sink     cfg
);
    import bdq_pkg::*;

    cmd_t cmd;

    // Capacity register takes a word every cycle.
    assign cfg.ready = 1'b1;

    bdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    bdq_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .kind        (req.kind),
        .value       (req.value),
        .cfg_we      (cfg.valid),
        .cfg_data    (cfg.data),
        .ok          (rsp.ok),
        .front_value (rsp.front_value),
        .rear_value  (rsp.rear_value),
        .is_empty    (rsp.is_empty),
        .is_full     (rsp.is_full)
    );

endmodule

@@ bench/deque_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the bounded deque: tracks capacity, predicts and compares every response.
module deque_checker
    import bdq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    bdq_req_if          req,
    bdq_rsp_if          rsp,
    bdq_cfg_if          cfg,
    output int unsigned outstanding,
    output int unsigned mismatches
);

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] rear_value;
        logic                     is_empty;
        logic                     is_full;
    } deque_view_t;

    // Shadow of the deque: ring of words, front index, live count, capacity.
    logic [DATA_W-1:0] ring_mem [DEPTH];
    logic [ADDR_W-1:0] head_ptr;
    logic [OCC_W-1:0]  live_cnt;
    logic [CAP_W-1:0]  cap_reg;
    deque_view_t       predicted_views [$];
    int unsigned       fault_cnt;

    assign mismatches = fault_cnt;

    function automatic logic [ADDR_W-1:0] slot_after(input int unsigned off);
        return ADDR_W'((int'(head_ptr) + off) % DEPTH);
    endfunction

    // Apply one operation to the shadow and return the view it leaves behind.
    function automatic deque_view_t step_deque(input logic [KIND_W-1:0] k,
                                               input logic [DATA_W-1:0] v);
        deque_view_t      res;
        logic [OCC_W-1:0] room;
        logic             at_cap;
        logic             none;
        room   = (cap_reg > CAP_W'(DEPTH)) ? OCC_W'(DEPTH) : OCC_W'(cap_reg);
        at_cap = live_cnt >= room;
        none   = live_cnt == '0;
        res.ok = 1'b0;
        case (k)
            KIND_PUSH_FRONT:
                if (!at_cap)
                begin
                    head_ptr           = slot_after(DEPTH - 1);
                    ring_mem[head_ptr] = v;
                    live_cnt           = live_cnt + 1'b1;
                    res.ok             = 1'b1;
                end
            KIND_PUSH_BACK:
                if (!at_cap)
                begin
                    ring_mem[slot_after(live_cnt)] = v;
                    live_cnt                       = live_cnt + 1'b1;
                    res.ok                         = 1'b1;
                end
            KIND_POP_FRONT:
                if (!none)
                begin
                    head_ptr = slot_after(1);
                    live_cnt = live_cnt - 1'b1;
                    res.ok   = 1'b1;
                end
            KIND_POP_BACK:
                if (!none)
                begin
                    live_cnt = live_cnt - 1'b1;
                    res.ok   = 1'b1;
                end
            KIND_QUERY:
                res.ok = 1'b1;
            default:
                res.ok = 1'b0;
        endcase
        if (live_cnt == '0)
        begin
            res.front_value = EMPTY_WORD;
            res.rear_value  = EMPTY_WORD;
        end
        else
        begin
            res.front_value = ring_mem[head_ptr];
            res.rear_value  = ring_mem[slot_after(live_cnt - 1'b1)];
        end
        res.is_empty = live_cnt == '0;
        res.is_full  = live_cnt >= room;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        deque_view_t want;
        if (!rst_n)
        begin
            head_ptr = '0;
            live_cnt = '0;
            cap_reg  = CAP_RESET;
            predicted_views.delete();
            fault_cnt = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                cap_reg = cfg.data;
            if (req.valid && req.ready)
                predicted_views.push_back(step_deque(req.kind, req.value));
            if (rsp.valid && rsp.ready)
            begin
                if (predicted_views.size() == 0)
                begin
                    $error("response word with nothing pending: ok=%0b front=%0d",
                           rsp.ok, rsp.front_value);
                    fault_cnt++;
                end
                else
                begin
                    want = predicted_views.pop_front();
                    if (rsp.ok !== want.ok)
                    begin
                        $error("ok: expected %0b, got %0b", want.ok, rsp.ok);
                        fault_cnt++;
                    end
                    if (rsp.front_value !== want.front_value)
                    begin
                        $error("front_value: expected %0d, got %0d",
                               want.front_value, rsp.front_value);
                        fault_cnt++;
                    end
                    if (rsp.rear_value !== want.rear_value)
                    begin
                        $error("rear_value: expected %0d, got %0d",
                               want.rear_value, rsp.rear_value);
                        fault_cnt++;
                    end
                    if (rsp.is_empty !== want.is_empty)
                    begin
                        $error("is_empty: expected %0b, got %0b", want.is_empty, rsp.is_empty);
                        fault_cnt++;
                    end
                    if (rsp.is_full !== want.is_full)
                    begin
                        $error("is_full: expected %0b, got %0b", want.is_full, rsp.is_full);
                        fault_cnt++;
                    end
                end
            end
            outstanding <= predicted_views.size();
        end
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the bounded deque testbench: clock, reset, request and capacity stimulus, verdict.
module tb_top;
    import bdq_pkg::*;

    // Kind codes the block has no operation for; it must answer them like a query with ok low.
    localparam logic [KIND_W-1:0] KIND_RSVD_LO  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_RSVD_MID = 3'd6;
    localparam logic [KIND_W-1:0] KIND_RSVD_HI  = 3'd7;

    localparam int RUN_LIMIT   = 200_000;  // cycles before the watchdog gives up
    localparam int HOLD_CYCLES = 300;      // long response stall to back up the block
    localparam int SETTLE      = 8;        // margin after the last response word comes back

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned outstanding;
    int unsigned mismatches;
    bit          calm_tail      = 1'b0;   // set for the last phase: no idling on either side
    bit          long_hold_req  = 1'b0;   // written by stimulus only
    bit          long_hold_done = 1'b0;   // written by the response side only

    bdq_req_if req_ch ();
    bdq_rsp_if rsp_ch ();
    bdq_cfg_if cfg_ch ();

    bounded_double_ended_queue_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    deque_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg         (cfg_ch),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Bound the run; a hung handshake or a lost response word ends up here.
    initial
    begin : watchdog
        int unsigned cycle_cnt;
        cycle_cnt = 0;
        while (cycle_cnt < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("status: fail");
        $finish;
    end

    // Response side: short random stalls, ready stretches, and one long hold-off
    // when stimulus asks for it so the block fills up and stops taking requests.
    initial
    begin : response_side
        forever
        begin
            if (long_hold_req && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!calm_tail && $urandom_range(0, 6) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Mostly random words, with the sign and magnitude extremes mixed in often.
    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return {1'b1, {(DATA_W-1){1'b0}}};
            1:       return {1'b0, {(DATA_W-1){1'b1}}};
            2:       return '1;
            3:       return '0;
            default: return $urandom();
        endcase
    endfunction

    // Pick an operation: pushes at push_pct percent, the rest mostly pops,
    // then queries and a trickle of unused kind codes.
    function automatic logic [KIND_W-1:0] pick_kind(input int unsigned push_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            return $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
        if (r < 94)
            return KIND_QUERY;
        return KIND_W'($urandom_range(KIND_RSVD_LO, KIND_RSVD_HI));
    endfunction

    // Offer one request word and hold it until the block takes it. Drop valid
    // for a short burst first now and then, except in the calm tail.
    task automatic issue_op(input logic [KIND_W-1:0] k, input logic [DATA_W-1:0] v);
        if (!calm_tail && $urandom_range(0, 5) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.kind  <= k;
        req_ch.value <= v;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Stop offering and wait until every predicted response word has come back,
    // then let the pipeline settle.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write the capacity register with the block idle.
    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        drain_results();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= cap;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_mix(input int unsigned n, input int unsigned push_pct);
        for (int unsigned i = 0; i < n; i++)
            issue_op(pick_kind(push_pct), pick_word());
    endtask

    initial
    begin : stimulus
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.kind  <= KIND_QUERY;
        req_ch.value <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= CAP_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset capacity: queries and pops on an empty deque, then extreme words
        // pushed at both ends, the unused kind codes, and a drain back to empty.
        issue_op(KIND_QUERY, pick_word());
        issue_op(KIND_POP_FRONT, pick_word());
        issue_op(KIND_POP_BACK, pick_word());
        issue_op(KIND_PUSH_FRONT, {1'b1, {(DATA_W-1){1'b0}}});
        issue_op(KIND_PUSH_BACK, {1'b0, {(DATA_W-1){1'b1}}});
        issue_op(KIND_PUSH_FRONT, '1);
        issue_op(KIND_PUSH_BACK, '0);
        issue_op(KIND_QUERY, '1);
        issue_op(KIND_RSVD_LO, pick_word());
        issue_op(KIND_RSVD_MID, pick_word());
        issue_op(KIND_RSVD_HI, pick_word());
        issue_op(KIND_POP_FRONT, pick_word());
        issue_op(KIND_POP_BACK, pick_word());
        issue_op(KIND_POP_FRONT, pick_word());
        issue_op(KIND_POP_BACK, pick_word());

        // Zero capacity: every push is refused, empty and full both read high.
        set_capacity('0);
        issue_op(KIND_PUSH_FRONT, pick_word());
        issue_op(KIND_PUSH_BACK, pick_word());
        issue_op(KIND_QUERY, pick_word());

        // Fill a three-entry deque and push once more into the full one.
        set_capacity(CAP_W'(3));
        issue_op(KIND_PUSH_BACK, pick_word());
        issue_op(KIND_PUSH_FRONT, pick_word());
        issue_op(KIND_PUSH_BACK, pick_word());
        issue_op(KIND_PUSH_FRONT, pick_word());

        // Drop capacity below the entries held: they stay, pushes are refused,
        // pops still work and bring the count down to the new limit.
        set_capacity(CAP_W'(1));
        issue_op(KIND_PUSH_BACK, pick_word());
        issue_op(KIND_POP_FRONT, pick_word());
        issue_op(KIND_POP_BACK, pick_word());

        // Random traffic at small capacities, where full and empty come often, then just above the depth.
        set_capacity(CAP_W'(2));
        run_mix(50, 50);
        set_capacity(CAP_W'(1));
        run_mix(50, 50);
        set_capacity(CAP_W'($urandom_range(3, 16)));
        run_mix(50, 50);
        set_capacity(CAP_W'(DEPTH + 1));
        run_mix(50, 55);

        // Capacity far above the store depth saturates at the depth. Push almost
        // only, so the ring wraps and fills up; stall the response side early on
        // so the block backs up and holds off its request side.
        set_capacity('1);
        long_hold_req = 1'b1;
        run_mix(1040, 99);
        run_mix(60, 40);

        // Exactly the store depth, then a capacity of one with the deque well
        // above it; no idling on either side in the last run.
        set_capacity(CAP_W'(DEPTH));
        run_mix(20, 50);
        set_capacity(CAP_W'(1));
        calm_tail = 1'b1;
        run_mix(50, 30);

        drain_results();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
